// ===== hdl/mif_pkg.sv =====
package mif_pkg;

  localparam int CHANNELS_DEF  = 8;
  localparam int MAX_ORDER_DEF = 2;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 32;
  localparam int CH_W      = 3;
  localparam int CH_SPAN   = 2 ** CH_W;
  localparam int ORDER_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // five products plus rounding bias, with headroom for the signed difference
  localparam int ACC_W     = PROD_W + 3;
  localparam int YF_W      = ACC_W - FRAC_W;
  localparam int ROUND_HALF = 2 ** (FRAC_W - 1);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A2    = 3'd5;

  localparam logic signed [COEF_W-1:0] B0_RESET = 32'sh0001_0000;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] Y_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] Y_MIN = 24'sh800000;

  typedef enum logic [1:0] {
    KIND_FILTER,
    KIND_BYPASS,
    KIND_PRESET
  } kind_t;

  typedef struct packed {
    logic                       op;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] output_preset;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
  } out_item_t;

  typedef struct packed {
    kind_t                      kind;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] preset;
  } entry_t;

  typedef struct packed {
    logic [ORDER_W-1:0]       order;
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_b2;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
  } coef_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic p_vld;
    logic m_vld;
    logic a_vld;
  } bk_status_t;

endpackage

// ===== hdl/multichannel_iir_filter.sv =====
// Throughput: one item per cycle while out_stall is low and neighboring filter
// items use different channels; a filter item on the channel of a filter or
// preset item still in the three-stage multiply/sum pipeline waits for its
// history write, so a same-channel filter item enters only after the one
// before it has left the partial sum stage.
// Reset (synchronous, rst_n low): history cleared to zero, registers to defaults.
module multichannel_iir_filter #(
  parameter int CHANNELS  = mif_pkg::CHANNELS_DEF,
  parameter int MAX_ORDER = mif_pkg::MAX_ORDER_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mif_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mif_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mif_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mif_pkg::COEF_W-1:0]      cfg_data
);
  import mif_pkg::*;

  logic [ORDER_W-1:0]       order_r;
  logic signed [COEF_W-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [ORDER_W-1:0]       eff_order;
  coef_cfg_t                cfg;

  logic       push;
  entry_t     push_entry;
  logic       pop;
  entry_t     head;
  q_status_t  q_st;
  bk_status_t bk_st;

  assign cfg_ready = 1'b1;

  // orders above the tap count act as the full order
  assign eff_order = (int'(order_r) > MAX_ORDER) ? ORDER_W'(MAX_ORDER) : order_r;

  assign cfg = '{order: eff_order, coef_b0: b0_r, coef_b1: b1_r, coef_b2: b2_r,
                 coef_a1: a1_r, coef_a2: a2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
      b0_r    <= B0_RESET;
      b1_r    <= '0;
      b2_r    <= '0;
      a1_r    <= '0;
      a2_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORDER: order_r <= cfg_data[ORDER_W-1:0];
        REG_B0:    b0_r    <= cfg_data;
        REG_B1:    b1_r    <= cfg_data;
        REG_B2:    b2_r    <= cfg_data;
        REG_A1:    a1_r    <= cfg_data;
        REG_A2:    a2_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mif_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .eff_order  (eff_order),
    .q_st       (q_st),
    .push       (push),
    .push_entry (push_entry)
  );

  mif_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_st       (q_st)
  );

  mif_back #(
    .CHANNELS  (CHANNELS),
    .MAX_ORDER (MAX_ORDER)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_st      (q_st),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .st        (bk_st)
  );

`ifndef SYNTH
  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_st.a_vld))
    else $error("result appeared with no item in the last stage");

  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(bk_st) && out_valid))
    else $error("back pipeline moved while the result was stalled");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !q_st.empty)
    else $error("queued item lost");
`endif

endmodule

// ===== hdl/mif_front.sv =====
module mif_front #(
  parameter int CHANNELS = mif_pkg::CHANNELS_DEF
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mif_pkg::in_item_t             in_data,
  input  logic [mif_pkg::ORDER_W-1:0]   eff_order,
  input  mif_pkg::q_status_t            q_st,
  output logic                          push,
  output mif_pkg::entry_t               push_entry
);
  import mif_pkg::*;

  logic in_range;

  assign in_stall = q_st.full;
  assign in_range = (CHANNELS >= CH_SPAN) || (in_data.channel < CH_W'(CHANNELS));

  // drop items for channels that do not exist
  assign push = in_valid && !in_stall && in_range;

  always_comb begin
    push_entry.channel = in_data.channel;
    push_entry.sample  = in_data.sample;
    push_entry.preset  = in_data.output_preset;
    priority if (in_data.op == OP_PRESET) begin
      push_entry.kind = KIND_PRESET;
    end else if (eff_order == '0) begin
      push_entry.kind = KIND_BYPASS;
    end else begin
      push_entry.kind = KIND_FILTER;
    end
  end

endmodule

// ===== hdl/mif_queue.sv =====
module mif_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mif_pkg::entry_t    push_entry,
  input  logic               pop,
  output mif_pkg::entry_t    head,
  output mif_pkg::q_status_t q_st
);
  import mif_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign q_st.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_st.empty = (count_r == '0);
  assign head       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hdl/mif_back.sv =====
module mif_back #(
  parameter int CHANNELS  = mif_pkg::CHANNELS_DEF,
  parameter int MAX_ORDER = mif_pkg::MAX_ORDER_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mif_pkg::coef_cfg_t  cfg,
  input  mif_pkg::q_status_t  q_st,
  input  mif_pkg::entry_t     head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mif_pkg::out_item_t  out_data,
  output mif_pkg::bk_status_t st
);
  import mif_pkg::*;

  localparam int HIST_DEPTH = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;
  localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  logic signed [SAMPLE_W-1:0] hist_x_r [HIST_DEPTH][MAX_ORDER];
  logic signed [SAMPLE_W-1:0] hist_y_r [HIST_DEPTH][MAX_ORDER];

  logic signed [COEF_W-1:0] coef_bt [MAX_ORDER];
  logic signed [COEF_W-1:0] coef_at [MAX_ORDER];

  // operand stage
  logic                       p_vld_r;
  kind_t                      p_kind_r;
  logic [CH_W-1:0]            p_ch_r;
  logic signed [SAMPLE_W-1:0] p_x_r, p_yp_r;
  logic signed [SAMPLE_W-1:0] p_xt_r [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] p_yt_r [MAX_ORDER];

  // product stage
  logic                       m_vld_r;
  kind_t                      m_kind_r;
  logic [CH_W-1:0]            m_ch_r;
  logic signed [SAMPLE_W-1:0] m_x_r, m_yp_r;
  logic signed [SAMPLE_W-1:0] m_xt_r [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] m_yt_r [MAX_ORDER];
  logic signed [PROD_W-1:0]   m_p0_r;
  logic signed [PROD_W-1:0]   m_pb_r [MAX_ORDER];
  logic signed [PROD_W-1:0]   m_pa_r [MAX_ORDER];

  // partial sum stage
  logic                       a_vld_r;
  kind_t                      a_kind_r;
  logic [CH_W-1:0]            a_ch_r;
  logic signed [SAMPLE_W-1:0] a_x_r, a_yp_r;
  logic signed [SAMPLE_W-1:0] a_xt_r [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] a_yt_r [MAX_ORDER];
  logic signed [ACC_W-1:0]    a_ff_r, a_fb_r;

  logic                       out_valid_r;
  out_item_t                  out_data_r;

  logic                       adv;
  logic                       hazard;
  logic [IDX_W-1:0]           head_idx, a_idx;
  logic signed [SAMPLE_W-1:0] op_x [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] op_y [MAX_ORDER];
  logic signed [PROD_W-1:0]   prod_b0;
  logic signed [PROD_W-1:0]   prod_b [MAX_ORDER];
  logic signed [PROD_W-1:0]   prod_a [MAX_ORDER];
  logic signed [ACC_W-1:0]    sum_ff, sum_fb, acc;
  logic signed [YF_W-1:0]     y_full;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       sat_hi, sat_lo;

  assign adv      = !out_valid_r || !out_stall;
  assign head_idx = head.channel[IDX_W-1:0];
  assign a_idx    = a_ch_r[IDX_W-1:0];

  // a filter item waits while an older item of its channel has yet to write history
  assign hazard =
      (p_vld_r && (p_kind_r != KIND_BYPASS) && (p_ch_r == head.channel)) ||
      (m_vld_r && (m_kind_r != KIND_BYPASS) && (m_ch_r == head.channel)) ||
      (a_vld_r && (a_kind_r != KIND_BYPASS) && (a_ch_r == head.channel));

  assign pop = adv && !q_st.empty && !((head.kind == KIND_FILTER) && hazard);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign st        = '{p_vld: p_vld_r, m_vld: m_vld_r, a_vld: a_vld_r};

  always_comb begin
    for (int t = 0; t < MAX_ORDER; t++) begin
      coef_bt[t] = (t == 0) ? cfg.coef_b1 : cfg.coef_b2;
      coef_at[t] = (t == 0) ? cfg.coef_a1 : cfg.coef_a2;
    end
  end

  // multiply: taps beyond the order contribute nothing
  always_comb begin
    prod_b0 = PROD_W'(p_x_r) * PROD_W'(cfg.coef_b0);
    for (int t = 0; t < MAX_ORDER; t++) begin
      op_x[t]   = (t < int'(cfg.order)) ? p_xt_r[t] : '0;
      op_y[t]   = (t < int'(cfg.order)) ? p_yt_r[t] : '0;
      prod_b[t] = PROD_W'(op_x[t]) * PROD_W'(coef_bt[t]);
      prod_a[t] = PROD_W'(op_y[t]) * PROD_W'(coef_at[t]);
    end
  end

  // fold the rounding half into the feedback sum
  always_comb begin
    sum_ff = ACC_W'(m_p0_r);
    sum_fb = -ACC_W'(ROUND_HALF);
    for (int t = 0; t < MAX_ORDER; t++) begin
      sum_ff = sum_ff + ACC_W'(m_pb_r[t]);
      sum_fb = sum_fb + ACC_W'(m_pa_r[t]);
    end
  end

  always_comb begin
    acc    = a_ff_r - a_fb_r;
    y_full = acc[ACC_W-1:FRAC_W];
    sat_hi = (y_full > YF_W'(Y_MAX));
    sat_lo = (y_full < YF_W'(Y_MIN));
    priority if (sat_hi) begin
      y_sat = Y_MAX;
    end else if (sat_lo) begin
      y_sat = Y_MIN;
    end else begin
      y_sat = y_full[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r     <= 1'b0;
      m_vld_r     <= 1'b0;
      a_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p_vld_r     <= pop;
      m_vld_r     <= p_vld_r;
      a_vld_r     <= m_vld_r;
      out_valid_r <= a_vld_r && (a_kind_r != KIND_PRESET);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_kind_r <= head.kind;
      p_ch_r   <= head.channel;
      p_x_r    <= head.sample;
      p_yp_r   <= head.preset;
      for (int t = 0; t < MAX_ORDER; t++) begin
        p_xt_r[t] <= hist_x_r[head_idx][t];
        p_yt_r[t] <= hist_y_r[head_idx][t];
      end

      m_kind_r <= p_kind_r;
      m_ch_r   <= p_ch_r;
      m_x_r    <= p_x_r;
      m_yp_r   <= p_yp_r;
      m_p0_r   <= prod_b0;
      for (int t = 0; t < MAX_ORDER; t++) begin
        m_xt_r[t] <= p_xt_r[t];
        m_yt_r[t] <= p_yt_r[t];
        m_pb_r[t] <= prod_b[t];
        m_pa_r[t] <= prod_a[t];
      end

      a_kind_r <= m_kind_r;
      a_ch_r   <= m_ch_r;
      a_x_r    <= m_x_r;
      a_yp_r   <= m_yp_r;
      a_ff_r   <= sum_ff;
      a_fb_r   <= sum_fb;
      for (int t = 0; t < MAX_ORDER; t++) begin
        a_xt_r[t] <= m_xt_r[t];
        a_yt_r[t] <= m_yt_r[t];
      end

      if (a_vld_r) begin
        out_data_r.out_channel <= a_ch_r;
        if (a_kind_r == KIND_FILTER) begin
          out_data_r.filtered  <= y_sat;
          out_data_r.saturated <= sat_hi || sat_lo;
        end else begin
          out_data_r.filtered  <= a_x_r;
          out_data_r.saturated <= 1'b0;
        end
      end
    end
  end

  // history: age from the oldest tap down, or load every tap on preset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < HIST_DEPTH; c++) begin
        for (int t = 0; t < MAX_ORDER; t++) begin
          hist_x_r[c][t] <= '0;
          hist_y_r[c][t] <= '0;
        end
      end
    end else if (adv && a_vld_r) begin
      unique case (a_kind_r)
        KIND_FILTER: begin
          hist_x_r[a_idx][0] <= a_x_r;
          hist_y_r[a_idx][0] <= y_sat;
          for (int t = 1; t < MAX_ORDER; t++) begin
            if (t < int'(cfg.order)) begin
              hist_x_r[a_idx][t] <= a_xt_r[t-1];
              hist_y_r[a_idx][t] <= a_yt_r[t-1];
            end
          end
        end
        KIND_PRESET: begin
          for (int t = 0; t < MAX_ORDER; t++) begin
            hist_x_r[a_idx][t] <= a_x_r;
            hist_y_r[a_idx][t] <= a_yp_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== tb/multichannel_iir_filter_tb.sv =====
`timescale 1ns / 100ps

module multichannel_iir_filter_tb;
  import mif_pkg::*;

  localparam int NUM_CH        = CHANNELS_DEF;
  localparam int TAPS          = MAX_ORDER_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [COEF_W-1:0] COEF_ONE  = 32'h0001_0000;
  localparam logic [COEF_W-1:0] COEF_HALF = 32'h0000_8000;
  localparam logic [COEF_W-1:0] COEF_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN  = 32'h8000_0000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data  = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_toggle   = 1'b0;
  bit hold_seen     = 1'b0;
  int hold_left     = 0;
  int errors        = 0;
  int cycle_count   = 0;

  // filter state as the block should hold it
  logic [ORDER_W-1:0]         order_reg;
  logic signed [COEF_W-1:0]   coef_b [3];
  logic signed [COEF_W-1:0]   coef_a [3];
  logic signed [SAMPLE_W-1:0] x_hist [NUM_CH][TAPS];
  logic signed [SAMPLE_W-1:0] y_hist [NUM_CH][TAPS];
  out_item_t                  expected_samples [$];

  multichannel_iir_filter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** multichannel_iir_filter: FAILED **");
      $finish;
    end
  end

  task automatic clear_filter_state();
    order_reg = '0;
    coef_b[0] = B0_RESET;
    coef_b[1] = '0;
    coef_b[2] = '0;
    coef_a[0] = '0;
    coef_a[1] = '0;
    coef_a[2] = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      for (int t = 0; t < TAPS; t++) begin
        x_hist[c][t] = '0;
        y_hist[c][t] = '0;
      end
    end
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    case (idx)
      REG_ORDER: order_reg = val[ORDER_W-1:0];
      REG_B0:    coef_b[0] = val;
      REG_B1:    coef_b[1] = val;
      REG_B2:    coef_b[2] = val;
      REG_A1:    coef_a[1] = val;
      REG_A2:    coef_a[2] = val;
      default: ;
    endcase
  endtask

  // Update channel state for one item; return 1 with the sample it yields.
  function automatic bit filter_sample(input in_item_t it, output out_item_t res);
    logic signed [SAMPLE_W-1:0] x;
    longint acc;
    longint y;
    int     ch;
    int     eff;
    bit     sat;
    res = '0;
    x   = it.sample;
    ch  = int'(it.channel);
    sat = 1'b0;
    if (ch >= NUM_CH) return 1'b0;
    if (it.op == OP_PRESET) begin
      for (int t = 0; t < TAPS; t++) begin
        x_hist[ch][t] = it.sample;
        y_hist[ch][t] = it.output_preset;
      end
      return 1'b0;
    end
    eff = (int'(order_reg) > TAPS) ? TAPS : int'(order_reg);
    if (eff == 0) begin
      y = longint'(x);
    end else begin
      acc = longint'(coef_b[0]) * longint'(x);
      for (int t = 0; t < eff; t++) begin
        acc += longint'(coef_b[t+1]) * longint'(x_hist[ch][t]);
        acc -= longint'(coef_a[t+1]) * longint'(y_hist[ch][t]);
      end
      y = (acc + longint'(ROUND_HALF)) >>> FRAC_W;
      if (y > longint'(Y_MAX)) begin
        y   = longint'(Y_MAX);
        sat = 1'b1;
      end
      if (y < longint'(Y_MIN)) begin
        y   = longint'(Y_MIN);
        sat = 1'b1;
      end
      // age from the oldest tap down
      for (int t = eff - 1; t > 0; t--) begin
        x_hist[ch][t] = x_hist[ch][t-1];
        y_hist[ch][t] = y_hist[ch][t-1];
      end
      x_hist[ch][0] = x;
      y_hist[ch][0] = y[SAMPLE_W-1:0];
    end
    res.out_channel = it.channel;
    res.filtered    = y[SAMPLE_W-1:0];
    res.saturated   = sat;
    return 1'b1;
  endfunction

  task automatic check_sample(input out_item_t got);
    out_item_t want;
    if (expected_samples.size() == 0) begin
      $display("%0t: unexpected sample, expected none actual ch %0d y %0d sat %0b",
               $time, got.out_channel, $signed(got.filtered), got.saturated);
      errors++;
      return;
    end
    want = expected_samples.pop_front();
    if (got.out_channel !== want.out_channel) begin
      $display("%0t: out_channel mismatch, expected %0d actual %0d",
               $time, want.out_channel, got.out_channel);
      errors++;
    end
    if (got.filtered !== want.filtered) begin
      $display("%0t: filtered mismatch, expected %0d actual %0d",
               $time, $signed(want.filtered), $signed(got.filtered));
      errors++;
    end
    if (got.saturated !== want.saturated) begin
      $display("%0t: saturated mismatch, expected %0b actual %0b",
               $time, want.saturated, got.saturated);
      errors++;
    end
  endtask

  // result side: check accepted samples and drive stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_sample(out_data);
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_item(input in_item_t it);
    out_item_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (filter_sample(it, res)) expected_samples.push_back(res);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    // let a trailing preset finish its history write
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(input logic [ORDER_W-1:0] order,
                            input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2);
    wait_idle();
    write_reg(REG_ORDER, {{(COEF_W-ORDER_W){1'b0}}, order});
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
  endtask

  function automatic in_item_t make_item(input logic op, input int ch, input int x, input int yp);
    in_item_t it;
    it.op            = op;
    it.channel       = ch[CH_W-1:0];
    it.sample        = x[SAMPLE_W-1:0];
    it.output_preset = yp[SAMPLE_W-1:0];
    return it;
  endfunction

  function automatic int random_value(input int full_pct);
    int v;
    if ($urandom_range(99) < full_pct) begin
      v = $urandom();
      v = v >>> (32 - SAMPLE_W);
    end else begin
      v = int'($urandom_range(0, 40000)) - 20000;
    end
    return v;
  endfunction

  function automatic logic [COEF_W-1:0] random_coef(input bit feedback);
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 70) begin
      v = int'($urandom_range(0, 2 * 65536)) - 65536;
      if (feedback) v = v / 2;
      return v;
    end
    if (pick < 90) return $urandom();
    case ($urandom_range(2))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      default: return '0;
    endcase
  endfunction

  function automatic in_item_t random_item();
    logic op;
    op = ($urandom_range(99) < 15) ? OP_PRESET : OP_FILTER;
    return make_item(op, $urandom_range(0, NUM_CH - 1), random_value(30), random_value(50));
  endfunction

  task automatic set_random_filter();
    set_filter(ORDER_W'($urandom_range(0, 3)), random_coef(1'b0), random_coef(1'b0),
               random_coef(1'b0), random_coef(1'b1), random_coef(1'b1));
  endtask

  // Reset registers give a pass-through; history must stay untouched.
  task automatic test_bypass();
    send_item(make_item(OP_FILTER, 0, 8388607, 0));
    send_item(make_item(OP_FILTER, 1, -8388608, 0));
    send_item(make_item(OP_FILTER, 7, -1, 0));
    send_item(make_item(OP_PRESET, 3, 1000, -500));
    send_item(make_item(OP_FILTER, 3, 7, 0));
    set_filter(2'd1, COEF_ONE, COEF_ONE, '0, COEF_ONE, '0);
    send_item(make_item(OP_FILTER, 3, 0, 0));
  endtask

  // Taps past the order neither count nor age; order 3 clamps to 2.
  task automatic test_unused_taps();
    set_filter(2'd1, COEF_ONE, COEF_HALF, COEF_MAX, 32'h0000_4000, COEF_MIN);
    send_item(make_item(OP_PRESET, 4, 2000, -3000));
    send_item(make_item(OP_FILTER, 4, 10, 0));
    send_item(make_item(OP_FILTER, 4, 20, 0));
    set_filter(2'd3, COEF_ONE, COEF_HALF, COEF_HALF, 32'h0000_4000, 32'h0000_2000);
    send_item(make_item(OP_FILTER, 4, 30, 0));
  endtask

  // Clip both ways, feed clipped outputs back, round halves upward.
  task automatic test_saturation();
    set_filter(2'd2, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
    send_item(make_item(OP_FILTER, 5, 8388607, 0));
    send_item(make_item(OP_FILTER, 5, -8388608, 0));
    send_item(make_item(OP_FILTER, 5, 8388607, 0));
    send_item(make_item(OP_FILTER, 5, -8388608, 0));
    set_filter(2'd1, COEF_HALF, '0, '0, '0, '0);
    send_item(make_item(OP_FILTER, 6, 1, 0));
    send_item(make_item(OP_FILTER, 6, -1, 0));
    send_item(make_item(OP_FILTER, 6, 3, 0));
    send_item(make_item(OP_FILTER, 6, -3, 0));
  endtask

  task automatic test_spare_registers();
    wait_idle();
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    send_item(make_item(OP_FILTER, 6, 5, 0));
    send_item(make_item(OP_FILTER, 2, -7, 0));
  endtask

  // Hold the result side off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    set_random_filter();
    hold_toggle <= ~hold_toggle;
    for (int i = 0; i < 40; i++) begin
      send_item(make_item(OP_FILTER, i % NUM_CH, random_value(30), 0));
    end
  endtask

  task automatic test_random_stream(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    for (int k = 0; k < 3; k++) begin
      set_random_filter();
      for (int i = 0; i < 55; i++) send_item(random_item());
    end
  endtask

  initial begin
    clear_filter_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 29;
    recv_idle_pct <= 86;
    test_bypass();
    test_unused_taps();
    test_saturation();
    test_spare_registers();
    test_backpressure();
    test_random_stream(29, 86);
    test_random_stream(86, 29);
    test_random_stream(0, 0);
    wait_idle();
    if (errors == 0) begin
      $display("** multichannel_iir_filter: PASSED **");
    end else begin
      $display("** multichannel_iir_filter: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mif_pkg.sv
hdl/mif_front.sv
hdl/mif_queue.sv
hdl/mif_back.sv
hdl/multichannel_iir_filter.sv
tb/multichannel_iir_filter_tb.sv
